// ===== design/sbpc_pkg.sv =====
// Shared types, constants and helpers for the swept box pair collision block.
package sbpc_pkg;

   localparam int QW     = 31;   // quotient bits, equals the time width
   localparam int MTW    = 31;   // max_time width
   localparam int NUMW   = 50;   // |d| << 16
   localparam int DENW   = 33;   // |v|
   localparam int RW     = 64;   // divider remainder width
   localparam int CW     = 50;   // wide contact sums
   localparam int ADDRW  = 3;
   localparam int QDEPTH_DEFAULT = 4;

   localparam logic [2:0] SIDE_NONE    = 3'd0;
   localparam logic [2:0] SIDE_OVERLAP = 3'd1;
   localparam logic [2:0] SIDE_TOP     = 3'd2;
   localparam logic [2:0] SIDE_BOTTOM  = 3'd3;
   localparam logic [2:0] SIDE_LEFT    = 3'd4;
   localparam logic [2:0] SIDE_RIGHT   = 3'd5;

   localparam logic REG_MAX_TIME = 1'b0;
   localparam logic [MTW-1:0] MAX_TIME_RESET = 31'd65536;

   typedef struct packed {
      logic                 ovl;
      logic                 y_ok;
      logic                 y_bot;
      logic signed [33:0]   face_y;
      logic signed [31:0]   bx;
      logic signed [32:0]   vx;
      logic signed [33:0]   left;
      logic signed [33:0]   right;
      logic                 x_ok;
      logic                 x_lft;
      logic signed [33:0]   face_x;
      logic signed [31:0]   by;
      logic signed [32:0]   vy;
      logic signed [33:0]   bottom;
      logic signed [33:0]   top;
      logic signed [31:0]   avx;
      logic signed [31:0]   avy;
   } item_type;

   typedef struct packed {
      item_type             item;
      logic [NUMW-1:0]      num_y;
      logic [NUMW-1:0]      num_x;
      logic [DENW-1:0]      den_y;
      logic [DENW-1:0]      den_x;
   } job_type;

   typedef struct packed {
      logic                 valid;
      item_type             item;
      logic [QW-1:0]        q_y;
      logic [QW-1:0]        q_x;
      logic                 big_y;
      logic                 big_x;
   } quo_type;

   // Clamp a wide signed sum to 32 bits.
   function automatic logic [31:0] sat32(input logic signed [CW-1:0] v);
      logic [31:0] r;
      if (&v[CW-1:31] || ~|v[CW-1:31]) begin
         r = v[31:0];
      end else if (v[CW-1]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

// ===== design/swept_box_pair_collision_top.sv =====
// Top level of the swept box pair collision block.
//
// Swept test of two moving axis-aligned boxes in Q16.16, one result per pair.
// Input: drive req_* and raise start; a pair transfers at a clock edge where
// start is high and busy is low. A new pair may follow every cycle while busy stays low.
// Output: each result is on the rsp_* ports for exactly one cycle with
// rsp_strobe high, in input order. The receiver cannot stall; results are
// never held back.
// Path: the front register, the queue, the pipelined divider (31 quotient
// stages, two lanes side by side) and four contact stages, in that order.
// Throughput: one pair per cycle while busy is low. busy rises only when the
// queue holds QDEPTH-1 jobs, which does not happen at the default depth while
// the back end drains one job per cycle.
// Config: max_time at APB byte address 0; write it only while idle.
// Reset (synchronous, high) empties the queue and pipeline and restores
// max_time to 1.0.
module swept_box_pair_collision_top import sbpc_pkg::*; #(
   parameter int QDEPTH = QDEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [30:0]        req_a_half_w,
   input  logic [30:0]        req_a_half_h,
   input  logic signed [31:0] req_a_pos_x,
   input  logic signed [31:0] req_a_pos_y,
   input  logic signed [31:0] req_a_vel_x,
   input  logic signed [31:0] req_a_vel_y,
   input  logic [30:0]        req_b_half_w,
   input  logic [30:0]        req_b_half_h,
   input  logic signed [31:0] req_b_pos_x,
   input  logic signed [31:0] req_b_pos_y,
   input  logic signed [31:0] req_b_vel_x,
   input  logic signed [31:0] req_b_vel_y,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_hit_side,
   output logic [30:0]        rsp_hit_time,
   output logic signed [31:0] rsp_rel_contact_x,
   output logic signed [31:0] rsp_rel_contact_y,
   output logic signed [31:0] rsp_world_contact_x,
   output logic signed [31:0] rsp_world_contact_y,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ADDRW-1:0]   paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [MTW-1:0] max_time_ff;
   logic           csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_time_ff <= MAX_TIME_RESET;
      end else if (csr_wr && (paddr[2] == REG_MAX_TIME)) begin
         max_time_ff <= pwdata[MTW-1:0];
      end
   end

   assign prdata = (paddr[2] == REG_MAX_TIME) ? {1'b0, max_time_ff} : '0;

   logic    accept, push, head_valid, almost_full;
   job_type push_job, head_job;
   quo_type quo;

   assign busy   = almost_full;
   assign accept = start && !almost_full;

   sbpc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .a_half_w (req_a_half_w),
      .a_half_h (req_a_half_h),
      .a_pos_x  (req_a_pos_x),
      .a_pos_y  (req_a_pos_y),
      .a_vel_x  (req_a_vel_x),
      .a_vel_y  (req_a_vel_y),
      .b_half_w (req_b_half_w),
      .b_half_h (req_b_half_h),
      .b_pos_x  (req_b_pos_x),
      .b_pos_y  (req_b_pos_y),
      .b_vel_x  (req_b_vel_x),
      .b_vel_y  (req_b_vel_y),
      .push     (push),
      .push_job (push_job)
   );

   sbpc_queue #(.DEPTH(QDEPTH)) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_job    (push_job),
      .pop         (head_valid),
      .head_valid  (head_valid),
      .head_job    (head_job),
      .almost_full (almost_full)
   );

   sbpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (head_valid),
      .in_job   (head_job),
      .out_quo  (quo)
   );

   sbpc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .quo      (quo),
      .max_time (max_time_ff),
      .strobe   (rsp_strobe),
      .hit_side (rsp_hit_side),
      .hit_time (rsp_hit_time),
      .rel_x    (rsp_rel_contact_x),
      .rel_y    (rsp_rel_contact_y),
      .world_x  (rsp_world_contact_x),
      .world_y  (rsp_world_contact_y)
   );

endmodule

// ===== design/sbpc_front.sv =====
// Front end: registers a pair, builds the grown faces and sets up both sweeps.
module sbpc_front import sbpc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [30:0]          a_half_w,
   input  logic [30:0]          a_half_h,
   input  logic signed [31:0]   a_pos_x,
   input  logic signed [31:0]   a_pos_y,
   input  logic signed [31:0]   a_vel_x,
   input  logic signed [31:0]   a_vel_y,
   input  logic [30:0]          b_half_w,
   input  logic [30:0]          b_half_h,
   input  logic signed [31:0]   b_pos_x,
   input  logic signed [31:0]   b_pos_y,
   input  logic signed [31:0]   b_vel_x,
   input  logic signed [31:0]   b_vel_y,
   output logic                 push,
   output job_type              push_job
);

   logic                 vld_ff;
   logic [30:0]          aw_ff, ah_ff, bw_ff, bh_ff;
   logic signed [31:0]   ax_ff, ay_ff, avx_ff, avy_ff, bx_ff, by_ff, bvx_ff, bvy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= accept;
      end
      if (accept) begin
         aw_ff  <= a_half_w;
         ah_ff  <= a_half_h;
         ax_ff  <= a_pos_x;
         ay_ff  <= a_pos_y;
         avx_ff <= a_vel_x;
         avy_ff <= a_vel_y;
         bw_ff  <= b_half_w;
         bh_ff  <= b_half_h;
         bx_ff  <= b_pos_x;
         by_ff  <= b_pos_y;
         bvx_ff <= b_vel_x;
         bvy_ff <= b_vel_y;
      end
   end

   logic signed [33:0] top, bottom, left, right, bx34, by34, face_y, face_x;
   logic signed [32:0] vx, vy, nvx, nvy;
   logic signed [34:0] dy, dx, ndy, ndx;
   logic               y_bot, x_lft, y_ok, x_ok;
   logic [33:0]        ady, adx;

   always_comb begin
      top    = {{2{ay_ff[31]}}, ay_ff} + $signed({3'b0, ah_ff}) + $signed({3'b0, bh_ff});
      bottom = {{2{ay_ff[31]}}, ay_ff} - $signed({3'b0, ah_ff}) - $signed({3'b0, bh_ff});
      left   = {{2{ax_ff[31]}}, ax_ff} - $signed({3'b0, aw_ff}) - $signed({3'b0, bw_ff});
      right  = {{2{ax_ff[31]}}, ax_ff} + $signed({3'b0, aw_ff}) + $signed({3'b0, bw_ff});
      bx34   = {{2{bx_ff[31]}}, bx_ff};
      by34   = {{2{by_ff[31]}}, by_ff};
      vx     = {bvx_ff[31], bvx_ff} - {avx_ff[31], avx_ff};
      vy     = {bvy_ff[31], bvy_ff} - {avy_ff[31], avy_ff};
      nvx    = -vx;
      nvy    = -vy;
      // moving up meets the bottom face, moving right meets the left face
      y_bot  = !vy[32] && (vy != '0);
      x_lft  = !vx[32] && (vx != '0);
      face_y = y_bot ? bottom : top;
      face_x = x_lft ? left : right;
      dy     = {face_y[33], face_y} - {by34[33], by34};
      dx     = {face_x[33], face_x} - {bx34[33], bx34};
      ndy    = -dy;
      ndx    = -dx;
      ady    = dy[34] ? ndy[33:0] : dy[33:0];
      adx    = dx[34] ? ndx[33:0] : dx[33:0];
      y_ok   = (vy != '0) && ((dy == '0) || (dy[34] == vy[32]));
      x_ok   = (vx != '0) && ((dx == '0) || (dx[34] == vx[32]));

      push_job.item.ovl    = (by34 < top) && (by34 > bottom) && (bx34 < right) && (bx34 > left);
      push_job.item.y_ok   = y_ok;
      push_job.item.y_bot  = y_bot;
      push_job.item.face_y = face_y;
      push_job.item.bx     = bx_ff;
      push_job.item.vx     = vx;
      push_job.item.left   = left;
      push_job.item.right  = right;
      push_job.item.x_ok   = x_ok;
      push_job.item.x_lft  = x_lft;
      push_job.item.face_x = face_x;
      push_job.item.by     = by_ff;
      push_job.item.vy     = vy;
      push_job.item.bottom = bottom;
      push_job.item.top    = top;
      push_job.item.avx    = avx_ff;
      push_job.item.avy    = avy_ff;
      push_job.num_y       = {ady, 16'b0};
      push_job.num_x       = {adx, 16'b0};
      push_job.den_y       = vy[32] ? nvy : vy;
      push_job.den_x       = vx[32] ? nvx : vx;
   end

   assign push = vld_ff;

endmodule

// ===== design/sbpc_queue.sv =====
// Short job queue between the front end and the divide/contact back end.
module sbpc_queue import sbpc_pkg::*; #(
   parameter int DEPTH = QDEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job,
   output logic    almost_full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   job_type         mem [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            do_pop;

   always_comb begin
      do_pop = pop && (cnt_ff != '0);
      wr_in  = push ? ((wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop ? ((rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CNTW'(push) - CNTW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem[wr_ff] <= push_job;
      end
   end

   assign head_valid  = (cnt_ff != '0);
   assign head_job    = mem[rd_ff];
   // one slot kept free for the pair still in the front register
   assign almost_full = (cnt_ff >= CNTW'(DEPTH - 1));

endmodule

// ===== design/sbpc_div.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage per lane.
module sbpc_div import sbpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  job_type in_job,
   output quo_type out_quo
);

   logic [QW:0]     v_ff;
   item_type        it_ff [QW+1];
   logic [RW-1:0]   r_ff  [QW+1][2];
   logic [RW-1:0]   r_in  [QW+1][2];
   logic [DENW-1:0] d_ff  [QW+1][2];
   logic [QW-1:0]   q_ff  [QW+1][2];
   logic [QW-1:0]   q_in  [QW+1][2];
   logic            b_ff  [QW+1][2];

   always_comb begin
      logic [RW-1:0] trial;
      for (int s = 0; s <= QW; s++) begin
         for (int l = 0; l < 2; l++) begin
            r_in[s][l] = '0;
            q_in[s][l] = '0;
         end
      end
      r_in[0][0] = RW'(in_job.num_y);
      r_in[0][1] = RW'(in_job.num_x);
      for (int s = 1; s <= QW; s++) begin
         for (int l = 0; l < 2; l++) begin
            trial      = RW'(d_ff[s-1][l]) << (QW - s);
            r_in[s][l] = r_ff[s-1][l];
            q_in[s][l] = q_ff[s-1][l];
            if (r_ff[s-1][l] >= trial) begin
               r_in[s][l]        = r_ff[s-1][l] - trial;
               q_in[s][l][QW-s]  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[QW-1:0], in_valid};
      end
      it_ff[0]   <= in_job.item;
      d_ff[0][0] <= in_job.den_y;
      d_ff[0][1] <= in_job.den_x;
      // quotient of 2^31 or more is past any max_time
      b_ff[0][0] <= RW'(in_job.num_y) >= {in_job.den_y, {(RW-DENW){1'b0}}};
      b_ff[0][1] <= RW'(in_job.num_x) >= {in_job.den_x, {(RW-DENW){1'b0}}};
      for (int l = 0; l < 2; l++) begin
         r_ff[0][l] <= r_in[0][l];
         q_ff[0][l] <= q_in[0][l];
      end
      for (int s = 1; s <= QW; s++) begin
         it_ff[s] <= it_ff[s-1];
         for (int l = 0; l < 2; l++) begin
            r_ff[s][l] <= r_in[s][l];
            q_ff[s][l] <= q_in[s][l];
            d_ff[s][l] <= d_ff[s-1][l];
            b_ff[s][l] <= b_ff[s-1][l];
         end
      end
   end

   assign out_quo.valid = v_ff[QW];
   assign out_quo.item  = it_ff[QW];
   assign out_quo.q_y   = q_ff[QW][0];
   assign out_quo.q_x   = q_ff[QW][1];
   assign out_quo.big_y = b_ff[QW][0];
   assign out_quo.big_x = b_ff[QW][1];

endmodule

// ===== design/sbpc_back.sv =====
// Back end: contact points, face selection, world shift and saturation.
module sbpc_back import sbpc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  quo_type            quo,
   input  logic [MTW-1:0]     max_time,
   output logic               strobe,
   output logic [2:0]         hit_side,
   output logic [QW-1:0]      hit_time,
   output logic signed [31:0] rel_x,
   output logic signed [31:0] rel_y,
   output logic signed [31:0] world_x,
   output logic signed [31:0] world_y
);

   // stage 1: time check and cross-axis products
   logic               s1_v_ff, s1_hy_ff, s1_hx_ff;
   item_type           s1_it_ff;
   logic [QW-1:0]      s1_ty_ff, s1_tx_ff;
   logic signed [63:0] s1_py_ff, s1_px_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= quo.valid;
      end
      s1_it_ff <= quo.item;
      s1_ty_ff <= quo.q_y;
      s1_tx_ff <= quo.q_x;
      s1_hy_ff <= quo.item.y_ok && !quo.big_y && (quo.q_y <= max_time);
      s1_hx_ff <= quo.item.x_ok && !quo.big_x && (quo.q_x <= max_time);
      s1_py_ff <= $signed({1'b0, quo.q_y}) * quo.item.vx;
      s1_px_ff <= $signed({1'b0, quo.q_x}) * quo.item.vy;
   end

   // stage 2: span check and priority selection
   logic signed [CW-1:0] c_y, c_x, sel_cx, sel_cy;
   logic                 hit_y, hit_x;
   logic [2:0]           sel_side;
   logic [QW-1:0]        sel_t;

   always_comb begin
      c_y   = {{18{s1_it_ff.bx[31]}}, s1_it_ff.bx} + {{2{s1_py_ff[63]}}, s1_py_ff[63:16]};
      c_x   = {{18{s1_it_ff.by[31]}}, s1_it_ff.by} + {{2{s1_px_ff[63]}}, s1_px_ff[63:16]};
      hit_y = s1_hy_ff
              && (c_y >= $signed({{16{s1_it_ff.left[33]}}, s1_it_ff.left}))
              && (c_y <= $signed({{16{s1_it_ff.right[33]}}, s1_it_ff.right}));
      hit_x = s1_hx_ff
              && (c_x >= $signed({{16{s1_it_ff.bottom[33]}}, s1_it_ff.bottom}))
              && (c_x <= $signed({{16{s1_it_ff.top[33]}}, s1_it_ff.top}));
      // vertical face beats horizontal face beats overlap
      priority if (hit_x) begin
         sel_side = s1_it_ff.x_lft ? SIDE_LEFT : SIDE_RIGHT;
         sel_t    = s1_tx_ff;
         sel_cx   = {{16{s1_it_ff.face_x[33]}}, s1_it_ff.face_x};
         sel_cy   = c_x;
      end else if (hit_y) begin
         sel_side = s1_it_ff.y_bot ? SIDE_BOTTOM : SIDE_TOP;
         sel_t    = s1_ty_ff;
         sel_cx   = c_y;
         sel_cy   = {{16{s1_it_ff.face_y[33]}}, s1_it_ff.face_y};
      end else if (s1_it_ff.ovl) begin
         sel_side = SIDE_OVERLAP;
         sel_t    = '0;
         sel_cx   = {{18{s1_it_ff.bx[31]}}, s1_it_ff.bx};
         sel_cy   = {{18{s1_it_ff.by[31]}}, s1_it_ff.by};
      end else begin
         sel_side = SIDE_NONE;
         sel_t    = '0;
         sel_cx   = '0;
         sel_cy   = '0;
      end
   end

   logic                 s2_v_ff;
   logic [2:0]           s2_side_ff;
   logic [QW-1:0]        s2_t_ff;
   logic signed [CW-1:0] s2_cx_ff, s2_cy_ff;
   logic signed [31:0]   s2_avx_ff, s2_avy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
      end
      s2_side_ff <= sel_side;
      s2_t_ff    <= sel_t;
      s2_cx_ff   <= sel_cx;
      s2_cy_ff   <= sel_cy;
      s2_avx_ff  <= s1_it_ff.avx;
      s2_avy_ff  <= s1_it_ff.avy;
   end

   // stage 3: A's displacement over the hit time
   logic                 s3_v_ff;
   logic [2:0]           s3_side_ff;
   logic [QW-1:0]        s3_t_ff;
   logic signed [CW-1:0] s3_cx_ff, s3_cy_ff;
   logic signed [63:0]   s3_wx_ff, s3_wy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else begin
         s3_v_ff <= s2_v_ff;
      end
      s3_side_ff <= s2_side_ff;
      s3_t_ff    <= s2_t_ff;
      s3_cx_ff   <= s2_cx_ff;
      s3_cy_ff   <= s2_cy_ff;
      s3_wx_ff   <= s2_avx_ff * $signed({1'b0, s2_t_ff});
      s3_wy_ff   <= s2_avy_ff * $signed({1'b0, s2_t_ff});
   end

   // stage 4: output register
   logic signed [CW-1:0] wsum_x, wsum_y;
   logic                 strobe_ff;
   logic [2:0]           side_ff;
   logic [QW-1:0]        time_ff;
   logic [31:0]          rx_ff, ry_ff, wx_ff, wy_ff;

   always_comb begin
      wsum_x = s3_cx_ff + {{2{s3_wx_ff[63]}}, s3_wx_ff[63:16]};
      wsum_y = s3_cy_ff + {{2{s3_wy_ff[63]}}, s3_wy_ff[63:16]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= s3_v_ff;
      end
      side_ff <= s3_side_ff;
      time_ff <= s3_t_ff;
      rx_ff   <= sat32(s3_cx_ff);
      ry_ff   <= sat32(s3_cy_ff);
      wx_ff   <= sat32(wsum_x);
      wy_ff   <= sat32(wsum_y);
   end

   assign strobe   = strobe_ff;
   assign hit_side = side_ff;
   assign hit_time = time_ff;
   assign rel_x    = rx_ff;
   assign rel_y    = ry_ff;
   assign world_x  = wx_ff;
   assign world_y  = wy_ff;

endmodule

// ===== tb/tb_swept_box_pair_collision_top.sv =====
// Testbench for the swept box pair collision block: directed and random pairs checked against a predictor.
`timescale 1ns / 1ps
module tb_swept_box_pair_collision_top;
   import sbpc_pkg::*;

   localparam longint ONE = 65536;
   localparam int LATENCY_WAIT = 45;
   localparam int STALL_LIMIT = 4000;

   typedef struct {
      logic [30:0]        a_half_w;
      logic [30:0]        a_half_h;
      logic signed [31:0] a_pos_x;
      logic signed [31:0] a_pos_y;
      logic signed [31:0] a_vel_x;
      logic signed [31:0] a_vel_y;
      logic [30:0]        b_half_w;
      logic [30:0]        b_half_h;
      logic signed [31:0] b_pos_x;
      logic signed [31:0] b_pos_y;
      logic signed [31:0] b_vel_x;
      logic signed [31:0] b_vel_y;
   } box_pair_t;

   typedef struct {
      logic [2:0]  hit_side;
      logic [30:0] hit_time;
      logic [31:0] rel_contact_x;
      logic [31:0] rel_contact_y;
      logic [31:0] world_contact_x;
      logic [31:0] world_contact_y;
   } contact_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [30:0]        req_a_half_w = '0;
   logic [30:0]        req_a_half_h = '0;
   logic signed [31:0] req_a_pos_x = '0;
   logic signed [31:0] req_a_pos_y = '0;
   logic signed [31:0] req_a_vel_x = '0;
   logic signed [31:0] req_a_vel_y = '0;
   logic [30:0]        req_b_half_w = '0;
   logic [30:0]        req_b_half_h = '0;
   logic signed [31:0] req_b_pos_x = '0;
   logic signed [31:0] req_b_pos_y = '0;
   logic signed [31:0] req_b_vel_x = '0;
   logic signed [31:0] req_b_vel_y = '0;
   logic               rsp_strobe;
   logic [2:0]         rsp_hit_side;
   logic [30:0]        rsp_hit_time;
   logic signed [31:0] rsp_rel_contact_x;
   logic signed [31:0] rsp_rel_contact_y;
   logic signed [31:0] rsp_world_contact_x;
   logic signed [31:0] rsp_world_contact_y;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [ADDRW-1:0]   paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   logic [30:0] max_time_m;
   contact_t    pending_contacts[$];
   int          err_count = 0;
   int          stall_cycles = 0;
   bit          gaps_on = 1'b0;

   swept_box_pair_collision_top dut (.*);

   always #2 clock = ~clock;

   function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // floor of p / 2^16 toward minus infinity
   function automatic longint q16_floor(longint p);
      return p >>> 16;
   endfunction

   function automatic bit sweep_face(longint face, longint p_al, longint v_al,
                                     longint p_ac, longint v_ac, longint lo,
                                     longint hi, output longint t, output longint c);
      longint d, ad, av;
      d = face - p_al;
      t = 0;
      c = 0;
      if (v_al == 0) return 1'b0;
      if (d != 0 && ((d < 0) != (v_al < 0))) return 1'b0;
      ad = d < 0 ? -d : d;
      av = v_al < 0 ? -v_al : v_al;
      t = (ad << 16) / av;
      if (t > longint'(max_time_m)) return 1'b0;
      c = p_ac + q16_floor(t * v_ac);
      return (c >= lo && c <= hi);
   endfunction

   function automatic contact_t predict_contact(box_pair_t p);
      contact_t r;
      longint aw, ah, ax, ay, avx, avy, bw, bh, bx, by, vx, vy;
      longint top, bottom, left, right, face, t, cx, cy, tt, c;
      logic [2:0] side;
      aw = p.a_half_w;  ah = p.a_half_h;
      ax = p.a_pos_x;   ay = p.a_pos_y;
      avx = p.a_vel_x;  avy = p.a_vel_y;
      bw = p.b_half_w;  bh = p.b_half_h;
      bx = p.b_pos_x;   by = p.b_pos_y;
      vx = longint'(p.b_vel_x) - avx;
      vy = longint'(p.b_vel_y) - avy;
      top = ay + ah + bh;
      bottom = ay - ah - bh;
      left = ax - aw - bw;
      right = ax + aw + bw;
      side = SIDE_NONE;
      t = 0; cx = 0; cy = 0;
      if (by < top && by > bottom && bx < right && bx > left) begin
         side = SIDE_OVERLAP;
         cx = bx;
         cy = by;
      end
      if (vy != 0) begin
         face = vy > 0 ? bottom : top;
         if (sweep_face(face, by, vy, bx, vx, left, right, tt, c)) begin
            side = vy > 0 ? SIDE_BOTTOM : SIDE_TOP;
            t = tt; cx = c; cy = face;
         end
      end
      // vertical face checked last so it wins
      if (vx != 0) begin
         face = vx > 0 ? left : right;
         if (sweep_face(face, bx, vx, by, vy, bottom, top, tt, c)) begin
            side = vx > 0 ? SIDE_LEFT : SIDE_RIGHT;
            t = tt; cx = face; cy = c;
         end
      end
      r.hit_side = side;
      r.hit_time = t[30:0];
      r.rel_contact_x = clamp32(cx);
      r.rel_contact_y = clamp32(cy);
      if (side != SIDE_NONE) begin
         r.world_contact_x = clamp32(cx + q16_floor(avx * t));
         r.world_contact_y = clamp32(cy + q16_floor(avy * t));
      end else begin
         r.world_contact_x = '0;
         r.world_contact_y = '0;
      end
      return r;
   endfunction

   // values in whole units are scaled to Q16.16
   function automatic box_pair_t unit_pair(int aw, int ah, int ax, int ay, int avx, int avy,
                                           int bw, int bh, int bx, int by, int bvx, int bvy);
      box_pair_t p;
      p.a_half_w = 31'(longint'(aw) * ONE); p.a_half_h = 31'(longint'(ah) * ONE);
      p.a_pos_x = 32'(longint'(ax) * ONE);  p.a_pos_y = 32'(longint'(ay) * ONE);
      p.a_vel_x = 32'(longint'(avx) * ONE); p.a_vel_y = 32'(longint'(avy) * ONE);
      p.b_half_w = 31'(longint'(bw) * ONE); p.b_half_h = 31'(longint'(bh) * ONE);
      p.b_pos_x = 32'(longint'(bx) * ONE);  p.b_pos_y = 32'(longint'(by) * ONE);
      p.b_vel_x = 32'(longint'(bvx) * ONE); p.b_vel_y = 32'(longint'(bvy) * ONE);
      return p;
   endfunction

   function automatic logic signed [31:0] near_val(int span);
      return 32'($signed($urandom_range(2 * span * 65536)) - span * 65536);
   endfunction

   function automatic box_pair_t random_pair();
      box_pair_t p;
      int k;
      k = $urandom_range(9);
      if (k < 2) begin
         // raw noise over the full field ranges
         p.a_half_w = 31'($urandom); p.a_half_h = 31'($urandom);
         p.a_pos_x = $urandom;  p.a_pos_y = $urandom;
         p.a_vel_x = $urandom;  p.a_vel_y = $urandom;
         p.b_half_w = 31'($urandom); p.b_half_h = 31'($urandom);
         p.b_pos_x = $urandom;  p.b_pos_y = $urandom;
         p.b_vel_x = $urandom;  p.b_vel_y = $urandom;
      end else begin
         p.a_half_w = 31'($urandom_range(6 * 65536));
         p.a_half_h = 31'($urandom_range(6 * 65536));
         p.b_half_w = 31'($urandom_range(6 * 65536));
         p.b_half_h = 31'($urandom_range(6 * 65536));
         p.a_pos_x = k == 9 ? $urandom : near_val(100);
         p.a_pos_y = k == 9 ? $urandom : near_val(100);
         p.b_pos_x = p.a_pos_x + near_val(25);
         p.b_pos_y = p.a_pos_y + near_val(25);
         p.a_vel_x = near_val(20);
         p.a_vel_y = near_val(20);
         p.b_vel_x = near_val(30);
         p.b_vel_y = near_val(30);
         if ($urandom_range(5) == 0) p.b_vel_x = p.a_vel_x;
         if ($urandom_range(5) == 0) p.b_vel_y = p.a_vel_y;
      end
      return p;
   endfunction

   // drive one pair and hold start until the transfer happens
   task automatic send_pair(box_pair_t p);
      req_a_half_w <= p.a_half_w; req_a_half_h <= p.a_half_h;
      req_a_pos_x <= p.a_pos_x;   req_a_pos_y <= p.a_pos_y;
      req_a_vel_x <= p.a_vel_x;   req_a_vel_y <= p.a_vel_y;
      req_b_half_w <= p.b_half_w; req_b_half_h <= p.b_half_h;
      req_b_pos_x <= p.b_pos_x;   req_b_pos_y <= p.b_pos_y;
      req_b_vel_x <= p.b_vel_x;   req_b_vel_y <= p.b_vel_y;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_contacts.push_back(predict_contact(p));
      if (gaps_on && $urandom_range(3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_contacts.size() != 0) @(posedge clock);
      repeat (LATENCY_WAIT) @(posedge clock);
   endtask

   task automatic write_max_time(logic [30:0] value);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= ADDRW'(REG_MAX_TIME) << 2;
      pwdata <= {1'b0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      max_time_m = value;
   endtask

   task automatic test_directed_cases();
      box_pair_t p;
      send_pair(unit_pair(1, 1, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0));      // overlap
      send_pair(unit_pair(1, 1, 0, 0, 0, 0, 1, 1, 50, 50, 0, 0));    // no hit
      send_pair(unit_pair(1, 1, 0, 0, 0, 0, 1, 1, 0, 5, 0, -4));     // top
      send_pair(unit_pair(1, 1, 0, 0, 0, 0, 1, 1, 0, -5, 0, 4));     // bottom
      send_pair(unit_pair(1, 1, 0, 0, 0, 0, 1, 1, -5, 0, 4, 0));     // left
      send_pair(unit_pair(1, 1, 0, 0, 0, 0, 1, 1, 5, 0, -4, 0));     // right
      send_pair(unit_pair(1, 1, 0, 0, 0, 0, 1, 1, -5, -5, 4, 4));    // both faces, vertical wins
      send_pair(unit_pair(1, 1, 0, 0, 0, 0, 1, 1, 5, 5, 4, 4));      // moving apart
      send_pair(unit_pair(1, 1, 0, 0, 0, 0, 1, 1, 0, 20, 0, -4));    // too late
      send_pair(unit_pair(1, 1, 0, 0, 0, 0, 1, 1, 0, 2, 0, -1));     // touching, time zero
      send_pair(unit_pair(1, 1, 0, 0, 0, 0, 1, 1, 10, 5, 0, -4));    // outside face span
      send_pair(unit_pair(1, 1, 3, -2, 7, -9, 1, 1, 3, 4, 7, -13));  // A moving, world shift
      send_pair(unit_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 3, 0, -4));     // zero sizes
      send_pair(unit_pair(2, 2, 0, 0, 5, 5, 1, 1, 0, 0, 5, 5));      // overlap, no relative motion
      // extremes of every field
      p.a_half_w = '1; p.a_half_h = '1; p.b_half_w = '1; p.b_half_h = '1;
      p.a_pos_x = 32'h7FFF_FFFF; p.a_pos_y = 32'h7FFF_FFFF;
      p.a_vel_x = 32'h8000_0000; p.a_vel_y = 32'h8000_0000;
      p.b_pos_x = 32'h8000_0000; p.b_pos_y = 32'h8000_0000;
      p.b_vel_x = 32'h7FFF_FFFF; p.b_vel_y = 32'h7FFF_FFFF;
      send_pair(p);
      p.a_pos_x = 32'h8000_0000; p.a_pos_y = 32'h8000_0000;
      p.a_vel_x = 32'h7FFF_FFFF; p.a_vel_y = 32'h7FFF_FFFF;
      p.b_pos_x = 32'h7FFF_FFFF; p.b_pos_y = 32'h7FFF_FFFF;
      p.b_vel_x = 32'h8000_0000; p.b_vel_y = 32'h8000_0000;
      send_pair(p);
      p = '{default: '0};
      send_pair(p);
      // contact pushed far out by A's velocity, saturates
      p = unit_pair(1, 1, 32000, 0, 32767, 0, 1, 1, 32000, 8, 32767, -8);
      send_pair(p);
      drain_results();
   endtask

   task automatic test_random_pairs(int count);
      repeat (count) send_pair(random_pair());
      drain_results();
   endtask

   task automatic test_max_time_settings();
      write_max_time('0);
      test_directed_cases();
      test_random_pairs(100);
      write_max_time('1);
      test_directed_cases();
      test_random_pairs(200);
      write_max_time(31'($urandom_range(1, 4 * 65536)));
      test_random_pairs(150);
      write_max_time(31'd65536);
   endtask

   task automatic test_back_to_back();
      gaps_on = 1'b0;
      test_random_pairs(250);
   endtask

   always @(posedge clock) begin
      contact_t e;
      if (!reset && rsp_strobe) begin
         if (pending_contacts.size() == 0) begin
            $error("unexpected result transfer");
            err_count++;
         end else begin
            e = pending_contacts.pop_front();
            if (rsp_hit_side !== e.hit_side) begin
               $error("hit_side exp %0d got %0d", e.hit_side, rsp_hit_side);
               err_count++;
            end
            if (rsp_hit_time !== e.hit_time) begin
               $error("hit_time exp %h got %h", e.hit_time, rsp_hit_time);
               err_count++;
            end
            if (rsp_rel_contact_x !== e.rel_contact_x) begin
               $error("rel_contact_x exp %h got %h", e.rel_contact_x, rsp_rel_contact_x);
               err_count++;
            end
            if (rsp_rel_contact_y !== e.rel_contact_y) begin
               $error("rel_contact_y exp %h got %h", e.rel_contact_y, rsp_rel_contact_y);
               err_count++;
            end
            if (rsp_world_contact_x !== e.world_contact_x) begin
               $error("world_contact_x exp %h got %h", e.world_contact_x,
                      rsp_world_contact_x);
               err_count++;
            end
            if (rsp_world_contact_y !== e.world_contact_y) begin
               $error("world_contact_y exp %h got %h", e.world_contact_y,
                      rsp_world_contact_y);
               err_count++;
            end
         end
      end
   end

   // watchdog: cycles with no transfer on either side
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      max_time_m = MAX_TIME_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      gaps_on = 1'b1;
      test_directed_cases();
      test_random_pairs(200);
      test_max_time_settings();
      test_back_to_back();
      if (pending_contacts.size() != 0) begin
         $error("%0d results never arrived", pending_contacts.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
